@@ hw/rtl/xmpr_pkg.sv @@
package xmpr_pkg;

  localparam int NOTE_TABLE_SIZE = 96;
  localparam int QUEUE_DEPTH = 2;
  localparam int CNT_W = 13;
  localparam logic [5:0] NUM_CHANNELS_RESET = 6'd3;
  localparam logic [5:0] MAX_CHANNELS = 6'd32;
  localparam logic [1:0] REG_NUM_CHANNELS = 2'd0;

  localparam logic [7:0] NOTE_OFF = 8'd97;
  localparam logic [7:0] DRUM_NOTE_LO = 8'd49;
  localparam logic [7:0] DRUM_NOTE_HI = 8'd60;
  localparam logic [7:0] INSTR_DRUM_A = 8'd9;
  localparam logic [7:0] INSTR_DRUM_B = 8'd10;
  localparam logic [7:0] FX_EXTENDED = 8'h0e;
  localparam logic [3:0] FX_FINETUNE = 4'h5;
  localparam logic [7:0] DUTY_BASE = 8'h80;
  localparam logic [15:0] TONE_REST = 16'h0100;
  localparam logic [CNT_W-1:0] CNT_MAX = 13'd4095;

  localparam longint unsigned Rom_Div = 64'd58562090;

  typedef logic [CNT_W-1:0] rom_t [NOTE_TABLE_SIZE];

  typedef struct packed {
    logic       clear;
    logic [7:0] note;
    logic [7:0] instr;
    logic [7:0] effect;
    logic [7:0] param;
  } event_t;

  function automatic rom_t build_rom();
    rom_t r;
    longint unsigned semi_tenths [12];
    longint unsigned num;
    semi_tenths = '{64'd20930, 64'd22174, 64'd23492, 64'd24890, 64'd26370, 64'd27938,
                    64'd29600, 64'd31360, 64'd33224, 64'd35200, 64'd37292, 64'd39510};
    for (int i = 0; i < NOTE_TABLE_SIZE; i++) begin
      num = semi_tenths[i % 12] << (16 + (i / 12));
      r[i] = CNT_W'(num / Rom_Div);
    end
    return r;
  endfunction

  localparam rom_t CNT_ROM = build_rom();

endpackage

@@ hw/rtl/xmpr_front.sv @@
module xmpr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           pattern_byte_i,
  input  logic                 pattern_start_i,
  output logic                 evt_push_o,
  output xmpr_pkg::event_t     evt_o
);

  logic [4:0] mask_q, mask_d;
  logic       clr_q, clr_d;
  logic [7:0] note_q, note_d, instr_q, instr_d, effect_q, effect_d, param_q, param_d;

  logic [4:0] mask_cur;
  logic [7:0] note_cur, instr_cur, effect_cur, param_cur;
  logic       finish;

  always_comb begin
    mask_cur   = pattern_start_i ? 5'd0 : mask_q;
    note_cur   = (pattern_start_i || mask_q == 5'd0) ? 8'd0 : note_q;
    instr_cur  = (pattern_start_i || mask_q == 5'd0) ? 8'd0 : instr_q;
    effect_cur = (pattern_start_i || mask_q == 5'd0) ? 8'd0 : effect_q;
    param_cur  = (pattern_start_i || mask_q == 5'd0) ? 8'd0 : param_q;
    mask_d   = mask_cur;
    note_d   = note_cur;
    instr_d  = instr_cur;
    effect_d = effect_cur;
    param_d  = param_cur;
    finish   = 1'b0;
    if (mask_cur == 5'd0) begin
      if (pattern_byte_i[7]) begin
        mask_d = pattern_byte_i[4:0];
        finish = (pattern_byte_i[4:0] == 5'd0);
      end else begin
        note_d = pattern_byte_i;
        mask_d = 5'b11110;
      end
    end else begin
      priority if (mask_cur[0]) begin
        note_d    = pattern_byte_i;
        mask_d[0] = 1'b0;
      end else if (mask_cur[1]) begin
        instr_d   = pattern_byte_i;
        mask_d[1] = 1'b0;
      end else if (mask_cur[2]) begin
        // volume byte is dropped
        mask_d[2] = 1'b0;
      end else if (mask_cur[3]) begin
        effect_d  = pattern_byte_i;
        mask_d[3] = 1'b0;
      end else begin
        param_d   = pattern_byte_i;
        mask_d[4] = 1'b0;
      end
      finish = (mask_d == 5'd0);
    end
    // a row restart is carried to the back end with the next finished event
    clr_d = finish ? 1'b0 : (clr_q | pattern_start_i);
  end

  assign evt_push_o   = accept_i & finish;
  assign evt_o.clear  = clr_q | pattern_start_i;
  assign evt_o.note   = note_d;
  assign evt_o.instr  = instr_d;
  assign evt_o.effect = effect_d;
  assign evt_o.param  = param_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 5'd0;
      clr_q  <= 1'b0;
    end else if (accept_i) begin
      mask_q <= mask_d;
      clr_q  <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      note_q   <= note_d;
      instr_q  <= instr_d;
      effect_q <= effect_d;
      param_q  <= param_d;
    end
  end

endmodule

@@ hw/rtl/xmpr_queue.sv @@
module xmpr_queue #(
  parameter int Depth = xmpr_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xmpr_pkg::event_t data_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output xmpr_pkg::event_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  xmpr_pkg::event_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/xmpr_back.sv @@
module xmpr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [5:0]       num_channels_i,
  input  logic             evt_avail_i,
  input  xmpr_pkg::event_t evt_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [4:0]       drum_code_o,
  output logic [7:0]       tone0_high_o,
  output logic [7:0]       tone0_low_o,
  output logic [7:0]       tone1_high_o,
  output logic [7:0]       tone1_low_o,
  output logic [7:0]       tone2_high_o,
  output logic [7:0]       tone2_low_o
);

  localparam int CW = xmpr_pkg::CNT_W;

  logic [15:0] tone_q [3];
  logic [15:0] tone_d [3];
  logic [4:0]  ch_q, ch_d;
  logic [4:0]  drum_q, drum_d;
  logic        out_valid_q;
  logic [4:0]  out_drum_q;
  logic [15:0] out_tone_q [3];

  logic        slot_free, row_end;
  logic [5:0]  limit;
  logic [15:0] tone_base [3];
  logic [4:0]  ch_base, drum_base, drum_new;
  logic        note_ok;
  logic [6:0]  rom_idx;
  logic [CW-1:0] rom_cnt, cnt;
  logic signed [CW+1:0] tuned;
  logic [7:0]  duty_hi;
  logic [15:0] word;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = evt_avail_i && slot_free;

  always_comb begin
    note_ok = (evt_i.note != 8'd0) && (evt_i.note <= 8'(xmpr_pkg::NOTE_TABLE_SIZE)) &&
              (evt_i.instr < xmpr_pkg::INSTR_DRUM_A);
    rom_idx = note_ok ? 7'(evt_i.note - 8'd1) : 7'd0;
    rom_cnt = xmpr_pkg::CNT_ROM[rom_idx];
    cnt     = rom_cnt;
    tuned   = $signed({2'b00, rom_cnt}) + $signed({{(CW-2){1'b0}}, evt_i.param[3:0]})
              - $signed((CW+2)'(8));
    if (evt_i.effect == xmpr_pkg::FX_EXTENDED && evt_i.param[7:4] == xmpr_pkg::FX_FINETUNE) begin
      if (tuned < 0) begin
        cnt = '0;
      end else if (tuned > $signed({2'b00, xmpr_pkg::CNT_MAX})) begin
        cnt = xmpr_pkg::CNT_MAX;
      end else begin
        cnt = CW'(tuned);
      end
    end
    duty_hi = xmpr_pkg::DUTY_BASE | {4'(evt_i.instr[3:0] - 4'd1), 4'd0};
    if (evt_i.note == xmpr_pkg::NOTE_OFF) begin
      word = 16'd0;
    end else if (note_ok) begin
      word = {duty_hi | {4'd0, cnt[11:8]}, cnt[7:0]};
    end else begin
      word = xmpr_pkg::TONE_REST;
    end
  end

  always_comb begin
    if (num_channels_i == 6'd0) begin
      limit = 6'd1;
    end else if (num_channels_i > xmpr_pkg::MAX_CHANNELS) begin
      limit = xmpr_pkg::MAX_CHANNELS;
    end else begin
      limit = num_channels_i;
    end
    for (int k = 0; k < 3; k++) begin
      tone_base[k] = evt_i.clear ? 16'd0 : tone_q[k];
    end
    ch_base   = evt_i.clear ? 5'd0 : ch_q;
    drum_base = evt_i.clear ? 5'd0 : drum_q;
    for (int k = 0; k < 3; k++) begin
      tone_d[k] = (ch_base == 5'(k)) ? word : tone_base[k];
    end
    drum_new = drum_base;
    if (evt_i.note >= xmpr_pkg::DRUM_NOTE_LO && evt_i.note <= xmpr_pkg::DRUM_NOTE_HI) begin
      if (evt_i.instr == xmpr_pkg::INSTR_DRUM_A) begin
        drum_new = 5'(evt_i.note - 8'd47);
      end else if (evt_i.instr == xmpr_pkg::INSTR_DRUM_B) begin
        drum_new = 5'(evt_i.note - 8'd35);
      end
    end
    row_end = ({1'b0, ch_base} + 6'd1) >= limit;
    ch_d    = row_end ? 5'd0 : ch_base + 5'd1;
    drum_d  = row_end ? 5'd0 : drum_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= 5'd0;
      drum_q      <= 5'd0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        tone_q[k] <= 16'd0;
      end
    end else begin
      if (pop_o) begin
        ch_q   <= ch_d;
        drum_q <= drum_d;
        for (int k = 0; k < 3; k++) begin
          tone_q[k] <= tone_d[k];
        end
      end
      if (pop_o && row_end) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && row_end) begin
      out_drum_q <= drum_new;
      for (int k = 0; k < 3; k++) begin
        out_tone_q[k] <= tone_d[k];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drum_code_o  = out_drum_q;
  assign tone0_high_o = out_tone_q[0][15:8];
  assign tone0_low_o  = out_tone_q[0][7:0];
  assign tone1_high_o = out_tone_q[1][15:8];
  assign tone1_low_o  = out_tone_q[1][7:0];
  assign tone2_high_o = out_tone_q[2][15:8];
  assign tone2_low_o  = out_tone_q[2][7:0];

`ifndef ASSERT_OFF
  a_pop_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!out_valid_q || out_ready_i))
    else $error("event taken while result slot busy");
  a_row_end_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && row_end) |=> out_valid_o)
    else $error("row end did not raise a result");
  a_drum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drum_code_o != 5'd1 && drum_code_o <= 5'd25))
    else $error("drum code out of range");
  a_ch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, ch_q} < xmpr_pkg::MAX_CHANNELS))
    else $error("channel index beyond row");
`endif

endmodule

@@ hw/rtl/xm_pattern_row_to_tone_words_unit.sv @@
// Packed pattern row decoder. Takes one pattern byte per cycle on the input
// channel while the queue is not full (pattern_start_i restarts the row parse
// before its byte) and, when the last channel event of a row completes,
// delivers one result: the row's drum code and the tone words of channels
// 0..2. The byte parser feeds finished events through a small queue
// (QUEUE_DEPTH entries) to the tone stage, which does the counter ROM lookup,
// detune and clamp, so sustained rate is one byte per cycle while results
// are taken. A held result stalls the tone stage only; the parser keeps
// taking bytes until the queue fills. Register num_channels (byte address 0,
// reset 3) may only be written while the block is idle.
module xm_pattern_row_to_tone_words_unit #(
  parameter int QUEUE_DEPTH = xmpr_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pattern_byte_i,
  input  logic        pattern_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  drum_code_o,
  output logic [7:0]  tone0_high_o,
  output logic [7:0]  tone0_low_o,
  output logic [7:0]  tone1_high_o,
  output logic [7:0]  tone1_low_o,
  output logic [7:0]  tone2_high_o,
  output logic [7:0]  tone2_low_o
);

  logic [5:0]        num_channels_q;
  logic              accept, push, pop, full, empty;
  xmpr_pkg::event_t  evt_in, evt_out;

  assign pready = 1'b1;
  assign prdata = (paddr == xmpr_pkg::REG_NUM_CHANNELS) ? {26'd0, num_channels_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_channels_q <= xmpr_pkg::NUM_CHANNELS_RESET;
    end else if (psel && penable && pwrite) begin
      num_channels_q <= pwdata[5:0];
    end
  end

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  xmpr_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .pattern_byte_i,
    .pattern_start_i,
    .evt_push_o      (push),
    .evt_o           (evt_in)
  );

  xmpr_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (evt_in),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (evt_out)
  );

  xmpr_back u_back (
    .clk_i,
    .rst_ni,
    .num_channels_i (num_channels_q),
    .evt_avail_i    (!empty),
    .evt_i          (evt_out),
    .pop_o          (pop),
    .out_valid_o,
    .out_ready_i,
    .drum_code_o,
    .tone0_high_o,
    .tone0_low_o,
    .tone1_high_o,
    .tone1_low_o,
    .tone2_high_o,
    .tone2_low_o
  );

endmodule

@@ test/xm_pattern_row_to_tone_words_unit_tb.sv @@
module xm_pattern_row_to_tone_words_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xmpr_pkg::*;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } pat_byte_t;

  typedef struct packed {
    logic [4:0] drum;
    logic [7:0] t0h;
    logic [7:0] t0l;
    logic [7:0] t1h;
    logic [7:0] t1l;
    logic [7:0] t2h;
    logic [7:0] t2l;
  } row_words_t;

  // bit positions in a tag's field mask, in stream order
  localparam int FieldNote  = 0;
  localparam int FieldInstr = 1;
  localparam int FieldVol   = 2;
  localparam int FieldFx    = 3;
  localparam int FieldParam = 4;

  localparam int unsigned CycleLimit = 300000;
  localparam int QuietCycles = 20;
  localparam int HoldCycles = 400;
  localparam int NumPhases = 9;
  localparam int PhaseBytes = 155;

  localparam logic [5:0] ChannelPlan [NumPhases] = '{
    6'd3, 6'd1, 6'd32, 6'd0, 6'd2, 6'd63, 6'd5, 6'd33, 6'd3
  };

  // {start, byte}: empty tags, clamp, note off, instrument zero, drum conflict, rest
  localparam logic [8:0] DirectedBytes [24] = '{
    9'h180, 9'h080, 9'h0E0,
    9'h060, 9'h008, 9'h040, 9'h00E, 9'h05F,
    9'h083, 9'h061, 9'h001,
    9'h09B, 9'h001, 9'h000, 9'h00E, 9'h050,
    9'h0A3, 9'h031, 9'h009,
    9'h0C3, 9'h03C, 9'h00A,
    9'h081, 9'h0FF
  };

  localparam longint unsigned SemiTenths [12] = '{
    20930, 22174, 23492, 24890, 26370, 27938, 29600, 31360, 33224, 35200, 37292, 39510
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  pat_byte = '0;
  logic        pat_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  drum_code;
  logic [7:0]  tone0_high, tone0_low, tone1_high, tone1_low, tone2_high, tone2_low;

  pat_byte_t   byte_q [$];
  row_words_t  row_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned byte_total = 0;
  int unsigned bytes_taken = 0;
  int unsigned rows_checked = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // decoder shadow state
  logic [5:0]  nch_cfg = NUM_CHANNELS_RESET;
  int unsigned chan_idx = 0;
  logic [4:0]  pend = '0;
  logic [7:0]  ev_note = '0;
  logic [7:0]  ev_instr = '0;
  logic [7:0]  ev_fx = '0;
  logic [7:0]  ev_prm = '0;
  logic [15:0] tone_q [3] = '{16'h0, 16'h0, 16'h0};
  logic [4:0]  drum_acc = '0;

  xm_pattern_row_to_tone_words_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .pattern_byte_i  (pat_byte),
    .pattern_start_i (pat_start),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .drum_code_o     (drum_code),
    .tone0_high_o    (tone0_high),
    .tone0_low_o     (tone0_low),
    .tone1_high_o    (tone1_high),
    .tone1_low_o     (tone1_low),
    .tone2_high_o    (tone2_high),
    .tone2_low_o     (tone2_low)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int row_len(logic [5:0] n);
    if (n == 0) return 1;
    if (n > MAX_CHANNELS) return int'(MAX_CHANNELS);
    return int'(n);
  endfunction

  function automatic int note_count(int idx);
    longint unsigned num;
    num = SemiTenths[idx % 12] << (16 + idx / 12);
    return int'(num / Rom_Div);
  endfunction

  function automatic logic [15:0] tone_word(logic [7:0] note, logic [7:0] instr,
                                            logic [7:0] fx, logic [7:0] prm);
    int cnt;
    logic [3:0] duty_nib;
    logic [15:0] w;
    w = TONE_REST;
    if (note >= 1 && note <= NOTE_TABLE_SIZE && instr < INSTR_DRUM_A) begin
      cnt = note_count(int'(note) - 1);
      if (fx == FX_EXTENDED && prm[7:4] == FX_FINETUNE) begin
        cnt = cnt + int'(prm[3:0]) - 8;
        if (cnt < 0) cnt = 0;
        if (cnt > int'(CNT_MAX)) cnt = int'(CNT_MAX);
      end
      duty_nib = instr[3:0] - 4'd1;
      w = {DUTY_BASE | {duty_nib, 4'h0} | {4'h0, 4'(cnt >> 8)}, 8'(cnt)};
    end
    if (note == NOTE_OFF) w = '0;
    return w;
  endfunction

  task automatic close_event();
    row_words_t r;
    if (chan_idx < 3) tone_q[chan_idx] = tone_word(ev_note, ev_instr, ev_fx, ev_prm);
    if (ev_note >= DRUM_NOTE_LO && ev_note <= DRUM_NOTE_HI) begin
      if (ev_instr == INSTR_DRUM_A) drum_acc = 5'(ev_note - DRUM_NOTE_LO + 8'd2);
      if (ev_instr == INSTR_DRUM_B) drum_acc = 5'(ev_note - DRUM_NOTE_LO + 8'd14);
    end
    ev_note = '0;
    ev_instr = '0;
    ev_fx = '0;
    ev_prm = '0;
    if (chan_idx + 1 >= row_len(nch_cfg)) begin
      r.drum = drum_acc;
      r.t0h = tone_q[0][15:8];
      r.t0l = tone_q[0][7:0];
      r.t1h = tone_q[1][15:8];
      r.t1l = tone_q[1][7:0];
      r.t2h = tone_q[2][15:8];
      r.t2l = tone_q[2][7:0];
      row_q.push_back(r);
      chan_idx = 0;
      drum_acc = '0;
    end else begin
      chan_idx = (chan_idx + 1) % 32;
    end
  endtask

  task automatic decode_byte(pat_byte_t it);
    if (it.start) begin
      chan_idx = 0;
      pend = '0;
      ev_note = '0;
      ev_instr = '0;
      ev_fx = '0;
      ev_prm = '0;
      tone_q = '{16'h0, 16'h0, 16'h0};
      drum_acc = '0;
    end
    if (pend == 0) begin
      ev_note = '0;
      ev_instr = '0;
      ev_fx = '0;
      ev_prm = '0;
      if (it.data[7]) begin
        pend = it.data[4:0];
        if (pend == 0) close_event();
      end else begin
        ev_note = it.data;
        pend = 5'h1e;
      end
    end else begin
      if (pend[FieldNote]) begin
        ev_note = it.data;
        pend[FieldNote] = 1'b0;
      end else if (pend[FieldInstr]) begin
        ev_instr = it.data;
        pend[FieldInstr] = 1'b0;
      end else if (pend[FieldVol]) begin
        pend[FieldVol] = 1'b0;
      end else if (pend[FieldFx]) begin
        ev_fx = it.data;
        pend[FieldFx] = 1'b0;
      end else begin
        ev_prm = it.data;
        pend[FieldParam] = 1'b0;
      end
      if (pend == 0) close_event();
    end
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    $display("%0t ERROR %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("row %0d %s: got %02h expected %02h",
                                rows_checked, name, got, want));
  endtask

  // driver: a new request goes out once the previous one is taken
  always @(posedge clk) begin
    pat_byte_t it;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_byte('{start: pat_start, data: pat_byte});
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = byte_q.pop_front();
          in_valid <= 1'b1;
          pat_byte <= it.data;
          pat_start <= it.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver backpressure
  always @(posedge clk) begin
    row_words_t got;
    row_words_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {drum_code, tone0_high, tone0_low, tone1_high, tone1_low, tone2_high, tone2_low};
        if (row_q.size() == 0) begin
          report_mismatch($sformatf("unexpected row result %h", got));
        end else begin
          want = row_q.pop_front();
          check_field("drum_code", 8'(got.drum), 8'(want.drum));
          check_field("tone0_high", got.t0h, want.t0h);
          check_field("tone0_low", got.t0l, want.t0l);
          check_field("tone1_high", got.t1h, want.t1h);
          check_field("tone1_low", got.t1l, want.t1l);
          check_field("tone2_high", got.t2h, want.t2h);
          check_field("tone2_low", got.t2l, want.t2l);
        end
        rows_checked++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = HoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d rows outstanding", cycles, row_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b, logic s);
    byte_q.push_back('{start: s, data: b});
    byte_total++;
  endtask

  task automatic gen_event(logic start);
    logic [7:0] f [5];
    logic [4:0] mask;
    int n;
    n = $urandom_range(99);
    f[FieldNote] = (n < 55) ? 8'($urandom_range(1, 96)) :
                   (n < 65) ? NOTE_OFF :
                   (n < 85) ? 8'($urandom_range(49, 60)) :
                   (n < 92) ? 8'd0 : 8'($urandom_range(98, 255));
    n = $urandom_range(99);
    f[FieldInstr] = (n < 50) ? 8'($urandom_range(0, 8)) :
                    (n < 80) ? 8'($urandom_range(9, 10)) : 8'($urandom);
    f[FieldVol] = 8'($urandom);
    f[FieldFx] = $urandom_range(1) ? FX_EXTENDED : 8'($urandom);
    f[FieldParam] = ($urandom_range(9) < 6) ? {FX_FINETUNE, 4'($urandom)} : 8'($urandom);
    if (!f[FieldNote][7] && $urandom_range(99) < 35) begin
      // full event: plain note byte, then the other four fields
      push_byte(f[FieldNote], start);
      for (int k = FieldInstr; k <= FieldParam; k++) push_byte(f[k], 1'b0);
    end else begin
      mask = 5'($urandom);
      push_byte({1'b1, 2'($urandom), mask}, start);
      for (int k = FieldNote; k <= FieldParam; k++)
        if (mask[k]) push_byte(f[k], 1'b0);
    end
  endtask

  task automatic gen_row();
    for (int c = 0; c < row_len(nch_cfg); c++) gen_event(c == 0 && $urandom_range(9) == 0);
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(19) == 0);
  endtask

  task automatic write_channels(logic [5:0] n);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_NUM_CHANNELS;
    pwdata <= {26'($urandom), n};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    nch_cfg = n;
    // read back in the following request
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {26'h0, n})
      report_mismatch($sformatf("num_channels read %h expected %h", prdata, n));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (byte_q.size() > 0 || in_valid || row_q.size() > 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_end;
    logic [5:0] nc;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < NumPhases; ph++) begin
      send_idle_pct = (ph < 3) ? 34 : (ph < 6) ? 69 : 0;
      recv_idle_pct = (ph < 3) ? 69 : (ph < 6) ? 34 : 0;
      nc = (ph == 6) ? 6'($urandom_range(4, 12)) : ChannelPlan[ph];
      write_channels(nc);
      if (ph == 0)
        foreach (DirectedBytes[i]) push_byte(DirectedBytes[i][7:0], DirectedBytes[i][8]);
      // long receiver stall while bytes keep coming
      if (ph == NumPhases - 1) holds_asked++;
      phase_end = byte_total + PhaseBytes;
      while (byte_total < phase_end) begin
        if ($urandom_range(99) < 85) gen_row();
        else gen_noise();
      end
      wait_quiet();
    end
    $display("run covered %0d pattern bytes and %0d row results over %0d channel settings",
             bytes_taken, rows_checked, NumPhases);
    $display("including empty tags, detune clamp, note off, drum conflict and a long stall");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/xmpr_pkg.sv
hw/rtl/xmpr_front.sv
hw/rtl/xmpr_queue.sv
hw/rtl/xmpr_back.sv
hw/rtl/xm_pattern_row_to_tone_words_unit.sv
test/xm_pattern_row_to_tone_words_unit_tb.sv
